/* hdl/lattice_stochastic_birth_macros.svh */
// ----------------------------------------------------------------------------
// Lattice stochastic birth assertion macros
// Concurrent assertion wrappers; empty bodies when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef LATTICE_STOCHASTIC_BIRTH_MACROS_SVH
`define LATTICE_STOCHASTIC_BIRTH_MACROS_SVH
`ifndef SYNTH
// check while out of reset
`define LSB_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("lattice_stochastic_birth assertion failed");
// check at every edge, reset included
`define LSB_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("lattice_stochastic_birth assertion failed");
`else
`define LSB_ASSERT(label, clk, rst_n, prop)
`define LSB_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

/* hdl/lsb_pkg.sv */
// ----------------------------------------------------------------------------
// Lattice stochastic birth package
// Field widths, cell, command, mode and register codes.
// ----------------------------------------------------------------------------
package lsb_pkg;

    // field widths
    localparam int CMD_W      = 2;
    localparam int COORD_W    = 6;
    localparam int RAND_W     = 16;
    localparam int CNT_W      = 13;
    localparam int SHARE_W    = 17;
    localparam int CELL_W     = 2;
    localparam int NB_W       = 3;
    localparam int MODE_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;

    // comparison width: largest of r*total and (coop+noncoop)*one
    localparam int CMP_W      = 30;
    localparam int PROD_W     = RAND_W + CNT_W;

    // number of distinct row or column codes at the input
    localparam int COORD_SPAN = 1 << COORD_W;

    localparam int DEF_SIDE   = 64;

    // cell codes
    localparam logic [CELL_W-1:0] CELL_EMPTY   = 2'd0;
    localparam logic [CELL_W-1:0] CELL_COOP    = 2'd1;
    localparam logic [CELL_W-1:0] CELL_NONCOOP = 2'd2;

    // commands; every other code reads the cell
    localparam logic [CMD_W-1:0] CMD_FILL   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;

    // birth rules
    localparam logic [MODE_W-1:0] MODE_UNIFORM = 2'd0;
    localparam logic [MODE_W-1:0] MODE_PROP    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_LOCAL   = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_REP_MODE      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COOP_SHARE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NONCOOP_SHARE = 2'd2;

    // register reset values
    localparam logic [MODE_W-1:0]  RST_REP_MODE = MODE_UNIFORM;
    localparam logic [SHARE_W-1:0] RST_SHARE    = 17'd32768;

endpackage

/* hdl/lattice_stochastic_birth.sv */
// ----------------------------------------------------------------------------
// Lattice stochastic birth
// Torus lattice of empty, cooperator and non-cooperator cells with totals.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall) takes one command word: fill an
//   empty cell by a birth draw, remove the agent of a cell, or read a cell.
//   Output channel (o_out_valid / i_out_stall) returns one result word per
//   command: the cell after the step, the placed flag, the agent and
//   cooperator totals and the occupied neighbour count.
//   Configuration channel (i_cfg_valid / o_cfg_ready) is always ready and
//   writes the birth rule and the two uniform shares.
// Timing:
//   The lattice lives in one memory with two registered read ports. A word
//   reads the target and its four neighbours: target and up, then down
//   and left, then right; it then decides and writes back. A new word is
//   taken only in idle, after the last one has written back. The output
//   register lets the next word enter while a result waits; a stalled
//   result holds the following word in write-back until the result is taken.
// Reset:
//   Totals clear and the memory is swept to empty, one cell per cycle, over
//   all SIDE*SIDE cells; words are stalled during the sweep.
// ----------------------------------------------------------------------------
`include "lattice_stochastic_birth_macros.svh"

module lattice_stochastic_birth
    import lsb_pkg::*;
#(
    parameter int SIDE = DEF_SIDE
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // command channel
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [CMD_W-1:0]      i_command,
    input  logic [COORD_W-1:0]    i_cell_row,
    input  logic [COORD_W-1:0]    i_cell_col,
    input  logic [RAND_W-1:0]     i_rand_value,
    input  logic [CNT_W-1:0]      i_prop_total,
    input  logic [CNT_W-1:0]      i_prop_coop,
    input  logic [CNT_W-1:0]      i_prop_noncoop,
    // result channel
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [CELL_W-1:0]     o_cell_state,
    output logic                  o_placed,
    output logic [CNT_W-1:0]      o_agent_count,
    output logic [CNT_W-1:0]      o_coop_count,
    output logic [NB_W-1:0]       o_neighbour_count,
    // configuration channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int DEPTH = SIDE * SIDE;
    localparam int CW    = $clog2(SIDE);
    localparam int AW    = $clog2(DEPTH);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD0,
        ST_RD1,
        ST_RD2,
        ST_WB
    } t_state;

    t_state r_state;
    t_state n_state;

    // lattice memory and its registered read ports
    logic [CELL_W-1:0] mem_cells [DEPTH];
    logic [CELL_W-1:0] r_rd_a;
    logic [CELL_W-1:0] r_rd_b;
    logic [AW-1:0]     r_addr_a;
    logic [AW-1:0]     r_addr_b;
    logic [AW-1:0]     n_addr_a;
    logic [AW-1:0]     n_addr_b;
    logic              w_we;
    logic [AW-1:0]     w_waddr;
    logic [CELL_W-1:0] w_wdata;

    // clearing sweep
    logic [AW-1:0]     r_clr;

    // held command
    logic [CMD_W-1:0]   r_cmd;
    logic [CW-1:0]      r_row;
    logic [CW-1:0]      r_col;
    logic [RAND_W-1:0]  r_rand;
    logic [CNT_W-1:0]   r_pt;
    logic [CNT_W-1:0]   r_pc;
    logic [CNT_W-1:0]   r_pn;

    // draw operands
    logic [CMP_W-1:0]   r_lhs;
    logic [CMP_W-1:0]   r_thr_coop;
    logic [CMP_W-1:0]   r_thr_all;
    logic               r_valid_g;
    logic [CMP_W-1:0]   n_lhs;
    logic [CMP_W-1:0]   n_thr_coop;
    logic [CMP_W-1:0]   n_thr_all;
    logic               n_valid_g;
    logic [PROD_W-1:0]  w_prod;

    // gathered cells
    logic [CELL_W-1:0]  r_tgt;
    logic [CELL_W-1:0]  r_up;
    logic [CELL_W-1:0]  r_dn;
    logic [CELL_W-1:0]  r_lf;

    // totals and registers
    logic [CNT_W-1:0]   r_agent_total;
    logic [CNT_W-1:0]   r_coop_total;
    logic [MODE_W-1:0]  r_rep_mode;
    logic [SHARE_W-1:0] r_coop_share;
    logic [SHARE_W-1:0] r_noncoop_share;

    // result register
    logic               r_out_valid;
    logic [CELL_W-1:0]  r_out_cell;
    logic               r_out_placed;
    logic [CNT_W-1:0]   r_out_agent;
    logic [CNT_W-1:0]   r_out_coop;
    logic [NB_W-1:0]    r_out_nb;

    // coordinates
    logic [CW-1:0] w_mod_tab [COORD_SPAN];
    logic [CW-1:0] w_row;
    logic [CW-1:0] w_col;
    logic [CW-1:0] w_up;
    logic [CW-1:0] w_dn;
    logic [CW-1:0] w_lf;
    logic [CW-1:0] w_rt;

    // decision
    logic [CELL_W-1:0] w_nb [4];
    logic [NB_W-1:0]   w_k;
    logic [NB_W-1:0]   w_kc;
    logic [CMP_W-1:0]  w_thr_coop;
    logic [CMP_W-1:0]  w_thr_all;
    logic              w_valid;
    logic              w_place;
    logic              w_remove;
    logic              w_is_coop;
    logic              w_wb_go;
    logic              w_accept;
    logic [CELL_W-1:0] w_new_cell;

    function automatic logic [AW-1:0] f_addr(input logic [CW-1:0] row,
                                             input logic [CW-1:0] col);
        return AW'(row) * AW'(SIDE) + AW'(col);
    endfunction

    // reduce input coordinates modulo SIDE by a constant table
    for (genvar g = 0; g < COORD_SPAN; g++) begin : g_mod
        assign w_mod_tab[g] = CW'(g % SIDE);
    end

    assign w_accept = i_in_valid && !o_in_stall;
    assign w_wb_go  = (r_state == ST_WB) && (!r_out_valid || !i_out_stall);

    // pick the coordinates in use: the incoming word in idle, else the held one
    always_comb begin
        w_row = (r_state == ST_IDLE) ? w_mod_tab[i_cell_row] : r_row;
        w_col = (r_state == ST_IDLE) ? w_mod_tab[i_cell_col] : r_col;
        w_up  = (w_row == '0) ? CW'(SIDE - 1) : w_row - 1'b1;
        w_dn  = (w_row == CW'(SIDE - 1)) ? '0 : w_row + 1'b1;
        w_lf  = (w_col == '0) ? CW'(SIDE - 1) : w_col - 1'b1;
        w_rt  = (w_col == CW'(SIDE - 1)) ? '0 : w_col + 1'b1;
    end

    // sequence read addresses: target and up, then down and left, then right
    always_comb begin
        n_addr_a = r_addr_a;
        n_addr_b = r_addr_b;
        case (r_state)
            ST_IDLE: begin
                n_addr_a = f_addr(w_row, w_col);
                n_addr_b = f_addr(w_up, w_col);
            end
            ST_RD0: begin
                n_addr_a = f_addr(w_dn, w_col);
                n_addr_b = f_addr(w_row, w_lf);
            end
            ST_RD1: begin
                n_addr_a = f_addr(w_row, w_rt);
            end
            default: begin
                n_addr_a = r_addr_a;
                n_addr_b = r_addr_b;
            end
        endcase
    end

    // form the draw operands of the global rules
    assign w_prod = PROD_W'(r_rand) * PROD_W'(r_pt);

    always_comb begin
        n_lhs      = CMP_W'(r_rand);
        n_thr_coop = '0;
        n_thr_all  = '0;
        n_valid_g  = 1'b0;
        case (r_rep_mode)
            MODE_UNIFORM: begin
                n_lhs      = CMP_W'(r_rand);
                n_thr_coop = CMP_W'(r_coop_share);
                n_thr_all  = CMP_W'(r_coop_share) + CMP_W'(r_noncoop_share);
                n_valid_g  = 1'b1;
            end
            MODE_PROP: begin
                n_lhs      = CMP_W'(w_prod);
                n_thr_coop = CMP_W'({r_pc, {RAND_W{1'b0}}});
                n_thr_all  = CMP_W'({({1'b0, r_pc} + {1'b0, r_pn}), {RAND_W{1'b0}}});
                n_valid_g  = (r_pt != '0);
            end
            MODE_LOCAL: begin
                n_lhs      = CMP_W'({r_rand, 2'b00});
            end
            default: begin
                n_valid_g  = 1'b0;
            end
        endcase
    end

    // count occupied and cooperator neighbours; right arrives from the read port
    always_comb begin
        w_nb[0] = r_up;
        w_nb[1] = r_dn;
        w_nb[2] = r_lf;
        w_nb[3] = r_rd_a;
        w_k     = '0;
        w_kc    = '0;
        for (int i = 0; i < 4; i++) begin
            w_k  = w_k + NB_W'(w_nb[i] != CELL_EMPTY);
            w_kc = w_kc + NB_W'(w_nb[i] == CELL_COOP);
        end
    end

    // decide the birth or the removal
    always_comb begin
        if (r_rep_mode == MODE_LOCAL) begin
            w_thr_coop = CMP_W'({w_kc, {RAND_W{1'b0}}});
            w_thr_all  = CMP_W'({w_k, {RAND_W{1'b0}}});
            w_valid    = (w_k != '0);
        end else begin
            w_thr_coop = r_thr_coop;
            w_thr_all  = r_thr_all;
            w_valid    = r_valid_g;
        end
        w_is_coop  = (r_lhs <= w_thr_coop);
        w_new_cell = w_is_coop ? CELL_COOP : CELL_NONCOOP;
        w_place    = 1'b0;
        w_remove   = 1'b0;
        case (r_cmd)
            CMD_FILL: begin
                w_place = (r_tgt == CELL_EMPTY) && w_valid && (r_lhs <= w_thr_all);
            end
            CMD_REMOVE: begin
                w_remove = (r_tgt != CELL_EMPTY);
            end
            default: begin
                w_place  = 1'b0;
                w_remove = 1'b0;
            end
        endcase
    end

    // drive the write port: sweep after reset, write back on a change
    always_comb begin
        if (r_state == ST_CLEAR) begin
            w_we    = 1'b1;
            w_waddr = r_clr;
            w_wdata = CELL_EMPTY;
        end else begin
            w_we    = w_wb_go && (w_place || w_remove);
            w_waddr = f_addr(r_row, r_col);
            w_wdata = w_place ? w_new_cell : CELL_EMPTY;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr == AW'(DEPTH - 1)) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (w_accept) n_state = ST_RD0;
            end
            ST_RD0:  n_state = ST_RD1;
            ST_RD1:  n_state = ST_RD2;
            ST_RD2:  n_state = ST_WB;
            ST_WB: begin
                if (w_wb_go) n_state = ST_IDLE;
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    // lattice memory
    always_ff @(posedge i_clk) begin
        if (w_we) mem_cells[w_waddr] <= w_wdata;
        r_rd_a <= mem_cells[r_addr_a];
        r_rd_b <= mem_cells[r_addr_b];
    end

    // state, datapath and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= ST_CLEAR;
            r_clr           <= '0;
            r_agent_total   <= '0;
            r_coop_total    <= '0;
            r_rep_mode      <= RST_REP_MODE;
            r_coop_share    <= RST_SHARE;
            r_noncoop_share <= RST_SHARE;
            r_out_valid     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_addr_a <= n_addr_a;
            r_addr_b <= n_addr_b;

            // advance the sweep
            if (r_state == ST_CLEAR) r_clr <= r_clr + 1'b1;

            // take configuration writes
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_REP_MODE:      r_rep_mode      <= i_cfg_data[MODE_W-1:0];
                    REG_COOP_SHARE:    r_coop_share    <= i_cfg_data[SHARE_W-1:0];
                    REG_NONCOOP_SHARE: r_noncoop_share <= i_cfg_data[SHARE_W-1:0];
                    default: begin
                    end
                endcase
            end

            // hold the accepted word
            if (w_accept) begin
                r_cmd  <= i_command;
                r_row  <= w_row;
                r_col  <= w_col;
                r_rand <= i_rand_value;
                r_pt   <= i_prop_total;
                r_pc   <= i_prop_coop;
                r_pn   <= i_prop_noncoop;
            end

            // capture operands and gathered cells
            if (r_state == ST_RD0) begin
                r_lhs      <= n_lhs;
                r_thr_coop <= n_thr_coop;
                r_thr_all  <= n_thr_all;
                r_valid_g  <= n_valid_g;
            end
            if (r_state == ST_RD1) begin
                r_tgt <= r_rd_a;
                r_up  <= r_rd_b;
            end
            if (r_state == ST_RD2) begin
                r_dn <= r_rd_a;
                r_lf <= r_rd_b;
            end

            // drop a taken result unless a new one replaces it
            if (r_out_valid && !i_out_stall && !w_wb_go) r_out_valid <= 1'b0;

            // write back totals and load the result
            if (w_wb_go) begin
                if (w_place) begin
                    r_agent_total <= r_agent_total + 1'b1;
                    if (w_is_coop) r_coop_total <= r_coop_total + 1'b1;
                    r_out_agent <= r_agent_total + 1'b1;
                    r_out_coop  <= w_is_coop ? r_coop_total + 1'b1 : r_coop_total;
                    r_out_cell  <= w_new_cell;
                end else if (w_remove) begin
                    r_agent_total <= r_agent_total - 1'b1;
                    if (r_tgt == CELL_COOP) r_coop_total <= r_coop_total - 1'b1;
                    r_out_agent <= r_agent_total - 1'b1;
                    r_out_coop  <= (r_tgt == CELL_COOP) ? r_coop_total - 1'b1
                                                        : r_coop_total;
                    r_out_cell  <= CELL_EMPTY;
                end else begin
                    r_out_agent <= r_agent_total;
                    r_out_coop  <= r_coop_total;
                    r_out_cell  <= r_tgt;
                end
                r_out_placed <= w_place;
                r_out_nb     <= w_k;
                r_out_valid  <= 1'b1;
            end
        end
    end

    assign o_in_stall        = (r_state != ST_IDLE);
    assign o_cfg_ready       = 1'b1;
    assign o_out_valid       = r_out_valid;
    assign o_cell_state      = r_out_cell;
    assign o_placed          = r_out_placed;
    assign o_agent_count     = r_out_agent;
    assign o_coop_count      = r_out_coop;
    assign o_neighbour_count = r_out_nb;

    // memory is written only by the sweep or at write-back
    `LSB_ASSERT(a_write_slot, i_clk, i_rst_n, w_we |-> (r_state == ST_CLEAR || r_state == ST_WB))
    // a new result comes only out of write-back
    `LSB_ASSERT(a_result_src, i_clk, i_rst_n, $rose(r_out_valid) |-> $past(r_state) == ST_WB)
    // a placement always leaves an agent in the cell
    `LSB_ASSERT(a_placed_cell, i_clk, i_rst_n, (o_out_valid && o_placed) |-> o_cell_state != CELL_EMPTY)
    // reset always restarts the clearing sweep
    `LSB_ASSERT_ALWAYS(a_reset_sweep, i_clk, !i_rst_n |=> (r_state == ST_CLEAR && r_clr == '0))

endmodule
